FILE: rtl/fnt_pkg.sv
// ============================================================================
// fnt_pkg: shared types and constants of the flat name table
// Field widths of the request and response channels, operation and status
// codes, and the sequencer states.
// ============================================================================
package fnt_pkg;

    localparam int TableDepth = 16;
    localparam int KeyBits    = 64;
    localparam int MaxResults = 16;

    localparam int KindW   = 2;
    localparam int KeyW    = 64;
    localparam int StatusW = 2;
    localparam int IndexW  = 4;
    localparam int CountW  = 5;

    typedef enum logic [KindW-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_LIST_LD,
        S_RESP
    } state_t;

endpackage

FILE: rtl/fnt_ifs.sv
// ============================================================================
// fnt_ifs: request and response channels of the flat name table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface fnt_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [fnt_pkg::KindW-1:0]  kind;
    logic [fnt_pkg::KeyW-1:0]   key_in;

    modport source (output valid, output kind, output key_in, input ready);
    modport sink   (input valid, input kind, input key_in, output ready);
endinterface

interface fnt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fnt_pkg::StatusW-1:0]  status;
    logic [fnt_pkg::KeyW-1:0]     key_out;
    logic [fnt_pkg::IndexW-1:0]   index_out;
    logic [fnt_pkg::CountW-1:0]   count_out;
    logic                         last;

    modport source (output valid, output status, output key_out, output index_out,
                    output count_out, output last, input ready);
    modport sink   (input valid, input status, input key_out, input index_out,
                    input count_out, input last, output ready);
endinterface

FILE: rtl/flat_name_table.sv
// ============================================================================
// flat_name_table: packed key table with insert, delete, search and list
// A small sequencer walks a key memory with one write and one registered read
// port through one shared compare unit, one slot per cycle.
// ============================================================================
// Usage:
//   cmd carries one request: kind (insert, delete, search, list) and key_in.
//   rsp returns one response per request, or one per live entry for a list
//   (at most MaxResults); last marks the final response of a request.
//   cmd.ready is high only while the sequencer is idle; one request is worked
//   on at a time.
// Sequence from request accept to response valid:
//   insert appends the key unless full, then responds; search/delete issue one
//   slot read per cycle and compare behind the registered memory read, until
//   a hit or every live slot is compared; a delete hit then reads the last
//   entry and moves it into the freed slot; list loads each listed entry from
//   the memory and then presents it, waiting while rsp is stalled.
// Reset empties the table (count zero); the key memory is not cleared since
// only slots below the count are ever read.
// When the receiver stalls, the response is held in its output register and
// the sequencer waits; no request is taken until the last response leaves.
// ============================================================================
module flat_name_table #(
    parameter int TABLE_DEPTH = fnt_pkg::TableDepth,
    parameter int KEY_BITS    = fnt_pkg::KeyBits
) (
    input  logic clk,
    input  logic rst_n,
    fnt_cmd_if.sink   cmd,
    fnt_rsp_if.source rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 6;

    // Key storage, one write and one registered read per cycle
    logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    fnt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    fnt_pkg::op_t    kind_reg, kind_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   pend_idx_reg, pend_idx_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;

    fnt_pkg::status_t                res_status_reg, res_status_next;
    logic [fnt_pkg::KeyW-1:0]        res_key_reg, res_key_next;
    logic [fnt_pkg::IndexW-1:0]      res_index_reg, res_index_next;
    logic [fnt_pkg::CountW-1:0]      res_count_reg, res_count_next;
    logic                            res_last_reg, res_last_next;

    logic [KEY_BITS-1:0] key_mask_in;
    logic                full;
    logic                issue;
    logic                hit;
    logic [CW-1:0]       last_slot;
    logic [SW-1:0]       list_pos;
    logic                list_last;
    logic [IW-1:0]       next_list_idx;

    assign key_mask_in   = cmd.key_in[KEY_BITS-1:0];
    assign full          = (count_reg == CW'(TABLE_DEPTH));
    assign issue         = (scan_idx_reg < count_reg);
    assign hit           = pend_reg && (rd_data_reg == key_reg);
    assign last_slot     = count_reg - CW'(1);
    assign list_pos      = SW'(hit_idx_reg) + SW'(1);
    assign list_last     = (list_pos == SW'(count_reg))
                        || (list_pos == SW'(fnt_pkg::MaxResults));
    assign next_list_idx = hit_idx_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fnt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload and index registers: no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_index_reg  <= res_index_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_idx_next    = hit_idx_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_index_next  = res_index_reg;
        res_count_next  = res_count_reg;
        res_last_next   = res_last_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = key_mask_in;
        cmd.ready       = 1'b0;
        rsp.valid       = 1'b0;

        case (state_reg)
            fnt_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    kind_next       = fnt_pkg::op_t'(cmd.kind);
                    key_next        = key_mask_in;
                    res_key_next    = fnt_pkg::KeyW'(key_mask_in);
                    res_index_next  = '0;
                    res_count_next  = fnt_pkg::CountW'(count_reg);
                    res_last_next   = 1'b1;
                    scan_idx_next   = '0;
                    pend_next       = 1'b0;
                    case (fnt_pkg::op_t'(cmd.kind))
                        fnt_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = fnt_pkg::ST_FULL;
                            end
                            else
                            begin
                                // append at the end of the live range
                                wr_en           = 1'b1;
                                wr_addr         = count_reg[IW-1:0];
                                count_next      = count_reg + CW'(1);
                                res_status_next = fnt_pkg::ST_OK;
                                res_index_next  = fnt_pkg::IndexW'(count_reg);
                                res_count_next  = fnt_pkg::CountW'(count_next);
                            end
                            state_next = fnt_pkg::S_RESP;
                        end
                        fnt_pkg::OP_DELETE, fnt_pkg::OP_SEARCH:
                        begin
                            state_next = fnt_pkg::S_SCAN;
                        end
                        fnt_pkg::OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fnt_pkg::ST_EMPTY;
                                state_next      = fnt_pkg::S_RESP;
                            end
                            else
                            begin
                                rd_addr      = '0;
                                hit_idx_next = '0;
                                state_next   = fnt_pkg::S_LIST_LD;
                            end
                        end
                        default:
                        begin
                            state_next = fnt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            fnt_pkg::S_SCAN:
            begin
                // issue one slot read per cycle, compare the one issued before
                rd_addr       = scan_idx_reg[IW-1:0];
                pend_next     = issue;
                pend_idx_next = scan_idx_reg[IW-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    hit_idx_next = pend_idx_reg;
                    if (kind_reg == fnt_pkg::OP_DELETE)
                    begin
                        state_next = fnt_pkg::S_MOVE_RD;
                    end
                    else
                    begin
                        res_status_next = fnt_pkg::ST_OK;
                        res_index_next  = fnt_pkg::IndexW'(pend_idx_reg);
                        state_next      = fnt_pkg::S_RESP;
                    end
                end
                else if (!issue && !pend_reg)
                begin
                    res_status_next = fnt_pkg::ST_NOT_FOUND;
                    res_index_next  = '0;
                    state_next      = fnt_pkg::S_RESP;
                end
            end

            fnt_pkg::S_MOVE_RD:
            begin
                rd_addr    = last_slot[IW-1:0];
                state_next = fnt_pkg::S_MOVE_WR;
            end

            fnt_pkg::S_MOVE_WR:
            begin
                // move the last entry into the freed slot and shrink
                wr_en           = 1'b1;
                wr_addr         = hit_idx_reg;
                wr_data         = rd_data_reg;
                count_next      = last_slot;
                res_status_next = fnt_pkg::ST_OK;
                res_index_next  = fnt_pkg::IndexW'(hit_idx_reg);
                res_count_next  = fnt_pkg::CountW'(last_slot);
                state_next      = fnt_pkg::S_RESP;
            end

            fnt_pkg::S_LIST_LD:
            begin
                res_status_next = fnt_pkg::ST_OK;
                res_key_next    = fnt_pkg::KeyW'(rd_data_reg);
                res_index_next  = fnt_pkg::IndexW'(hit_idx_reg);
                res_count_next  = fnt_pkg::CountW'(count_reg);
                res_last_next   = list_last;
                state_next      = fnt_pkg::S_RESP;
            end

            fnt_pkg::S_RESP:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    if (kind_reg == fnt_pkg::OP_LIST && !res_last_reg)
                    begin
                        // advance to the next listed slot
                        hit_idx_next = next_list_idx;
                        rd_addr      = next_list_idx;
                        state_next   = fnt_pkg::S_LIST_LD;
                    end
                    else
                    begin
                        state_next = fnt_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = fnt_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.status    = res_status_reg;
    assign rsp.key_out   = res_key_reg;
    assign rsp.index_out = res_index_reg;
    assign rsp.count_out = res_count_reg;
    assign rsp.last      = res_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("live count above table depth");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && rsp.valid))
        else $error("request taken while a response is pending");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.kind == fnt_pkg::OP_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the count");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fnt_pkg::S_MOVE_WR)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the count");

    a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fnt_pkg::S_LIST_LD) |-> (CW'(hit_idx_reg) < count_reg))
        else $error("list walked past the live range");

endmodule
